### sv/ud_pkg.sv
`timescale 1ns / 1ps

package ud_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned NIBBLE_W        = 4;
  localparam int unsigned CHAR_W          = 6;

  localparam logic [CHAR_W-1:0]   ASCII_ZERO = 6'h30;
  localparam logic [NIBBLE_W-1:0] BCD_LIMIT  = 4'd5;
  localparam logic [NIBBLE_W-1:0] BCD_ADJUST = 4'd3;

  typedef enum logic [1:0] {
    BackIdle,
    BackConv,
    BackEmit
  } back_state_e;

  typedef struct packed {
    logic valid;
    logic is_zero;
  } queue_head_t;

endpackage

### sv/ud_front.sv
`timescale 1ns / 1ps

module ud_front #(
  parameter int unsigned VALUE_WIDTH = ud_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [VALUE_WIDTH-1:0] in_value_i,
  output ud_pkg::queue_head_t    head_o,
  output logic [VALUE_WIDTH-1:0] head_value_o,
  input  logic                   pop_i
);

  logic [VALUE_WIDTH-1:0] val_q [2];
  logic                   zero_q [2];
  logic                   wr_ptr_q, wr_ptr_d;
  logic                   rd_ptr_q, rd_ptr_d;
  logic [1:0]             count_q, count_d;
  logic                   push, pop;

  assign in_ready_o = (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = head_o.valid && pop_i;

  assign head_o.valid   = (count_q != 2'd0);
  assign head_o.is_zero = zero_q[rd_ptr_q];
  assign head_value_o   = val_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // classify on entry: zero needs no conversion
  always_ff @(posedge clk_i) begin
    if (push) begin
      val_q[wr_ptr_q]  <= in_value_i;
      zero_q[wr_ptr_q] <= (in_value_i == '0);
    end
  end

endmodule

### sv/ud_back.sv
`timescale 1ns / 1ps

module ud_back #(
  parameter int unsigned VALUE_WIDTH = ud_pkg::VALUE_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ud_pkg::queue_head_t        head_i,
  input  logic [VALUE_WIDTH-1:0]     head_value_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ud_pkg::CHAR_W-1:0]  out_char_o,
  output logic                       out_last_o
);

  localparam int unsigned NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned BCD_W      = NUM_DIGITS * ud_pkg::NIBBLE_W;
  localparam int unsigned CNT_W      = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned DCNT_W     = $clog2(NUM_DIGITS + 1);

  ud_pkg::back_state_e state_q, state_d;

  logic [VALUE_WIDTH-1:0]         bin_q, bin_d;
  logic [BCD_W-1:0]               bcd_q, bcd_d;
  logic [BCD_W-1:0]               bcd_adj;
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic [DCNT_W-1:0]              dcnt_q, dcnt_d;
  logic                           started_q, started_d;
  logic                           out_valid_q, out_valid_d;
  logic [ud_pkg::CHAR_W-1:0]      out_char_q, out_char_d;
  logic                           out_last_q, out_last_d;
  logic [ud_pkg::NIBBLE_W-1:0]    top_digit;
  logic                           is_last, need_emit, out_free;

  // add-3 on every digit of five or more
  always_comb begin
    for (int i = 0; i < int'(NUM_DIGITS); i++) begin
      bcd_adj[i*ud_pkg::NIBBLE_W +: ud_pkg::NIBBLE_W] =
        (bcd_q[i*ud_pkg::NIBBLE_W +: ud_pkg::NIBBLE_W] >= ud_pkg::BCD_LIMIT) ?
        bcd_q[i*ud_pkg::NIBBLE_W +: ud_pkg::NIBBLE_W] + ud_pkg::BCD_ADJUST :
        bcd_q[i*ud_pkg::NIBBLE_W +: ud_pkg::NIBBLE_W];
    end
  end

  assign top_digit = bcd_q[BCD_W-1 -: ud_pkg::NIBBLE_W];
  assign is_last   = (dcnt_q == DCNT_W'(1));
  assign need_emit = started_q || (top_digit != '0) || is_last;
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    dcnt_d      = dcnt_q;
    started_d   = started_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    pop_o       = 1'b0;
    unique case (state_q)
      ud_pkg::BackIdle: begin
        pop_o = 1'b1;
        if (head_i.valid) begin
          bin_d     = head_value_i;
          bcd_d     = '0;
          cnt_d     = CNT_W'(VALUE_WIDTH);
          dcnt_d    = DCNT_W'(NUM_DIGITS);
          started_d = 1'b0;
          state_d   = head_i.is_zero ? ud_pkg::BackEmit : ud_pkg::BackConv;
        end
      end
      ud_pkg::BackConv: begin
        bcd_d = {bcd_adj[BCD_W-2:0], bin_q[VALUE_WIDTH-1]};
        bin_d = {bin_q[VALUE_WIDTH-2:0], 1'b0};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = ud_pkg::BackEmit;
        end
      end
      ud_pkg::BackEmit: begin
        if (!need_emit || out_free) begin
          bcd_d  = {bcd_q[BCD_W-ud_pkg::NIBBLE_W-1:0], {ud_pkg::NIBBLE_W{1'b0}}};
          dcnt_d = dcnt_q - DCNT_W'(1);
          if (need_emit) begin
            out_valid_d = 1'b1;
            out_char_d  = ud_pkg::ASCII_ZERO | {2'b00, top_digit};
            out_last_d  = is_last;
            started_d   = 1'b1;
          end
          if (is_last) begin
            state_d = ud_pkg::BackIdle;
          end
        end
      end
      default: begin
        state_d = ud_pkg::BackIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ud_pkg::BackIdle;
      cnt_q       <= '0;
      dcnt_q      <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dcnt_q      <= dcnt_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q      <= bin_d;
    bcd_q      <= bcd_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule

### sv/unsigned_to_decimal_ascii.sv
`timescale 1ns / 1ps
// path: the input queue, then a shift-and-add-3 conversion over all VALUE_WIDTH bits,
// then the decimal positions in turn (leading zeros are dropped without output)
// the back end takes a new number only after the last digit of the one before,
// as it has a single shared double-dabble register; zero skips the conversion
// the two-entry input queue takes numbers while a conversion runs
// reset: asynchronous, active low, empties the queue and returns the back end to idle
module unsigned_to_decimal_ascii #(
  parameter int unsigned VALUE_WIDTH = ud_pkg::VALUE_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // number_value, upper pad bits ignored
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // digit_char [5:0], zero pad [7:6]
  output logic [7:0]          m_axis_tdata_o,
  output logic                m_axis_tlast_o
);

  ud_pkg::queue_head_t          head;
  logic [VALUE_WIDTH-1:0]       head_value;
  logic                         pop;
  logic [ud_pkg::CHAR_W-1:0]    out_char;

  ud_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_value_i  (s_axis_tdata_i[VALUE_WIDTH-1:0]),
    .head_o      (head),
    .head_value_o(head_value),
    .pop_i       (pop)
  );

  ud_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .head_value_i(head_value),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (out_char),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, out_char};

endmodule

### sv/ud_checker.sv
`timescale 1ns / 1ps

module ud_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_i,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_i,
  input logic       m_axis_tlast_i
);

  logic in_run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_run_q <= 1'b0;
    end else if (m_axis_tvalid_i && m_axis_tready_i) begin
      in_run_q <= !m_axis_tlast_i;
    end
  end

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i)
    else $error("output item dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> $stable(m_axis_tdata_i) && $stable(m_axis_tlast_i))
    else $error("output item changed while stalled");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> m_axis_tdata_i >= 8'h30 && m_axis_tdata_i <= 8'h39)
    else $error("output is not an ascii digit");

  a_no_lead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !in_run_q && m_axis_tdata_i == 8'h30 |-> m_axis_tlast_i)
    else $error("leading zero emitted");

endmodule

bind unsigned_to_decimal_ascii ud_checker u_ud_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_i(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_i (m_axis_tdata_o),
  .m_axis_tlast_i (m_axis_tlast_o)
);

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned NUM_W          = 32;
  localparam int unsigned CHAR_W         = ud_pkg::CHAR_W;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = ud_pkg::ASCII_ZERO;
  localparam int unsigned DECIMAL_BASE   = 10;
  localparam int unsigned MAX_DIGITS     = 10;
  localparam int unsigned RANDOM_NUMBERS = 207;
  localparam int unsigned STALL_LIMIT    = 5000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned HOLD_AT_DIGIT  = 80;
  localparam int unsigned DRAIN_CYCLES   = 100;
  localparam int unsigned IDLE_PERCENT   = 29;

  typedef struct packed {
    logic [CHAR_W-1:0] digit;
    logic              last;
  } digit_item_t;

  class digit_scoreboard;
    digit_item_t expected_digits[$];
    int unsigned errors;
    int unsigned digits_checked;

    function new();
      errors         = 0;
      digits_checked = 0;
    endfunction

    task automatic report(input string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    // splits the number into decimal digits, most significant first
    function automatic void add_number(input logic [NUM_W-1:0] number);
      longint unsigned rest;
      logic [CHAR_W-1:0] rev[MAX_DIGITS];
      int unsigned n;
      digit_item_t item;
      rest = longint'(number);
      n    = 0;
      if (rest == 0) begin
        item.digit = ASCII_ZERO;
        item.last  = 1'b1;
        expected_digits.push_back(item);
        return;
      end
      while (rest != 0 && n < MAX_DIGITS) begin
        rev[n] = ASCII_ZERO + CHAR_W'(rest % DECIMAL_BASE);
        rest   = rest / DECIMAL_BASE;
        n++;
      end
      for (int k = int'(n) - 1; k >= 0; k--) begin
        item.digit = rev[k];
        item.last  = (k == 0);
        expected_digits.push_back(item);
      end
    endfunction

    task automatic check_char(input logic [CHAR_W-1:0] digit, input logic last);
      digit_item_t want;
      if (expected_digits.size() == 0) begin
        report($sformatf("unexpected digit 0x%02h last %0b", digit, last));
        return;
      end
      want = expected_digits.pop_front();
      digits_checked++;
      if (digit !== want.digit)
        report($sformatf("digit 0x%02h, wanted 0x%02h", digit, want.digit));
      if (last !== want.last)
        report($sformatf("tlast %0b, wanted %0b (digit 0x%02h)", last, want.last, digit));
    endtask

    function automatic int unsigned pending();
      return expected_digits.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [NUM_W-1:0] s_axis_tdata_i = '0;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [7:0]       m_axis_tdata_o;
  logic             m_axis_tlast_o;

  unsigned_to_decimal_ascii #(
    .VALUE_WIDTH(NUM_W)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #2 clk_i = ~clk_i;

  digit_scoreboard sb = new();

  logic        steady_phase = 1'b0;
  int unsigned numbers_sent = 0;
  int unsigned zeros_sent = 0;
  int unsigned ten_digit_sent = 0;
  int unsigned hold_cycles_done = 0;
  int unsigned stall_count = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", stall_count);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // output side: random back-pressure, one long hold-off
  initial begin
    bit hold_done;
    int unsigned hold_left;
    hold_done = 1'b0;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_char(m_axis_tdata_o[CHAR_W-1:0], m_axis_tlast_o);
      if (!hold_done && sb.digits_checked >= HOLD_AT_DIGIT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_axis_tready_i <= 1'b0;
        hold_left--;
        hold_cycles_done++;
      end else begin
        m_axis_tready_i <= steady_phase || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  task automatic send_number(input logic [NUM_W-1:0] number);
    int unsigned gap;
    gap = 0;
    if (!steady_phase)
      while ($urandom_range(0, 99) < IDLE_PERCENT) gap++;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= number;
    do @(posedge clk_i); while (!(s_axis_tvalid_i && s_axis_tready_o));
    sb.add_number(number);
    numbers_sent++;
    if (number == 0) zeros_sent++;
    if (number >= 32'd1000000000) ten_digit_sent++;
  endtask

  function automatic longint unsigned pow10(input int unsigned e);
    longint unsigned p;
    p = 1;
    repeat (e) p = p * DECIMAL_BASE;
    return p;
  endfunction

  function automatic logic [NUM_W-1:0] random_number();
    int unsigned pick;
    int unsigned d;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned r;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      d  = $urandom_range(1, MAX_DIGITS);
      lo = (d == 1) ? 0 : pow10(d - 1);
      hi = pow10(d) - 1;
      if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
      r  = {$urandom, $urandom};
      return NUM_W'(lo + r % (hi - lo + 1));
    end else if (pick < 85) begin
      return $urandom;
    end else if (pick < 93) begin
      return $urandom_range(0, 15);
    end else begin
      d = $urandom_range(1, MAX_DIGITS - 1);
      return NUM_W'(pow10(d) - longint'($urandom_range(0, 1)));
    end
  endfunction

  initial begin
    logic [NUM_W-1:0] directed[$];
    directed = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd101,
                 32'd999, 32'd1000, 32'd65535, 32'd99999, 32'd1000000,
                 32'd999999999, 32'd1000000000, 32'd1234567890, 32'h8000_0000,
                 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                 32'd0, 32'd7};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_number(directed[i]);
    for (int unsigned n = 0; n < RANDOM_NUMBERS; n++) begin
      steady_phase <= (n >= 120 && n < 170);
      send_number(random_number());
    end
    s_axis_tvalid_i <= 1'b0;
    steady_phase    <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d digits never arrived", sb.pending()));

    $display("run covered %0d numbers (%0d zero, %0d with ten digits), %0d digits checked",
             numbers_sent, zeros_sent, ten_digit_sent, sb.digits_checked);
    $display("output held off for %0d cycles; %0d mismatches", hold_cycles_done, sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
